// ===== design/packet_id_tracker_assert.svh =====
`ifndef PACKET_ID_TRACKER_ASSERT_SVH
`define PACKET_ID_TRACKER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PIT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("packet_id_tracker check failed");

// Next-cycle implication.
`define PIT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("packet_id_tracker check failed");

`endif

// ===== design/pit_pkg.sv =====
package pit_pkg;

   localparam int NUM_IDS  = 256;
   localparam int TAG_BITS = 32;

   localparam int IDX_W = $clog2(NUM_IDS);
   localparam int CNT_W = $clog2(NUM_IDS + 1);

   localparam logic [1:0] ACTION_RESERVE = 2'd0;
   localparam logic [1:0] ACTION_RELEASE = 2'd1;
   localparam logic [1:0] ACTION_UPDATE  = 2'd2;
   localparam logic [1:0] ACTION_FIND    = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE  = 2'd1;
   localparam logic [1:0] STATUS_MISS     = 2'd2;
   localparam logic [1:0] STATUS_REL_FREE = 2'd3;

   typedef logic [TAG_BITS-1:0] tag_type;

   typedef struct packed {
      tag_type    request_tag;
      tag_type    context_tag;
      logic [7:0] packet_code;
   } entry_type;

endpackage

// ===== design/pit_chan_if.sv =====
interface pit_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [7:0]  id;
   logic [31:0] request_tag;
   logic [31:0] context_tag;
   logic [7:0]  packet_code;
   logic [63:0] vector_high;
   logic [63:0] vector_low;
   logic        check_vector;

   modport source (output valid, action, id, request_tag, context_tag, packet_code,
                   vector_high, vector_low, check_vector, input ready);
   modport sink (input valid, action, id, request_tag, context_tag, packet_code,
                 vector_high, vector_low, check_vector, output ready);
endinterface

interface pit_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  result_id;
   logic [31:0] found_request;
   logic [31:0] found_context;
   logic [7:0]  found_code;
   logic [8:0]  in_use_count;

   modport source (output valid, status, result_id, found_request, found_context,
                   found_code, in_use_count, input ready);
   modport sink (input valid, status, result_id, found_request, found_context,
                 found_code, in_use_count, output ready);
endinterface

// ===== design/pit_ram.sv =====
module pit_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/packet_id_tracker.sv =====
// Channel   Dir   Role
// req_ch    in    reserve / release / update / find command
// rsp_ch    out   status, ID, found entry fields, in-use count
//
// Each transaction reads the free queue, entry and vector RAMs on accept, then
// decides and writes back in the execute state; no new transaction is taken
// until it leaves execute. Reset is synchronous and needs no clearing pass:
// queue slots not yet written read as their own index. When the result
// register is still full the execute cycle holds until rsp_ch is drained.
`include "packet_id_tracker_assert.svh"

module packet_id_tracker (
   input logic   clock,
   input logic   reset,
   pit_req_if.sink   req_ch,
   pit_rsp_if.source rsp_ch
);
   import pit_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;

   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [NUM_IDS-1:0] busy_ff, busy_in;

   logic [1:0]  act_ff;
   logic [7:0]  id_ff;
   logic [31:0] req_tag_ff;
   logic [31:0] ctx_tag_ff;
   logic [7:0]  code_ff;
   logic [63:0] vhi_ff;
   logic [63:0] vlo_ff;
   logic        chk_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  status_ff, status_in;
   logic [7:0]  rid_ff, rid_in;
   logic [31:0] freq_ff, freq_in;
   logic [31:0] fctx_ff, fctx_in;
   logic [7:0]  fcode_ff, fcode_in;

   logic req_fire, exec_go;

   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] id_idx;
   logic [7:0]       q_rdata;
   entry_type        ent_rdata;
   logic [127:0]     vec_rdata;

   logic             q_we;
   logic             ent_we;
   logic             vec_we;
   entry_type        ent_wdata;
   logic [7:0]       got_id;
   logic [IDX_W-1:0] got_idx;
   logic             id_ok;
   logic             busy_hit;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign exec_go  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = (state_ff == ST_IDLE);

   // Read addresses come straight from the request on accept, then hold.
   assign rd_idx = (state_ff == ST_IDLE) ? req_ch.id[IDX_W-1:0] : id_ff[IDX_W-1:0];
   assign id_idx = id_ff[IDX_W-1:0];

   pit_ram #(.WIDTH(8), .DEPTH(NUM_IDS)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (tail_ff),
      .wr_data (id_ff),
      .rd_addr (head_ff),
      .rd_data (q_rdata)
   );

   pit_ram #(.WIDTH($bits(entry_type)), .DEPTH(NUM_IDS)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (got_idx),
      .wr_data (ent_wdata),
      .rd_addr (rd_idx),
      .rd_data (ent_rdata)
   );

   pit_ram #(.WIDTH(128), .DEPTH(NUM_IDS)) u_vector_ram (
      .clock   (clock),
      .wr_en   (vec_we),
      .wr_addr (id_idx),
      .wr_data ({vhi_ff, vlo_ff}),
      .rd_addr (rd_idx),
      .rd_data (vec_rdata)
   );

   // Queue slots at or past the fill count are not read from RAM: they read as their own index.
   assign got_id  = (CNT_W'(head_ff) < fill_ff) ? q_rdata : 8'(head_ff);
   assign got_idx = got_id[IDX_W-1:0];
   assign id_ok   = ({1'b0, id_ff} < 9'(NUM_IDS));
   assign busy_hit = id_ok && busy_ff[id_idx];

   assign ent_wdata.request_tag = TAG_BITS'(req_tag_ff);
   assign ent_wdata.context_tag = TAG_BITS'(ctx_tag_ff);
   assign ent_wdata.packet_code = code_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      used_in      = used_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      status_in    = status_ff;
      rid_in       = rid_ff;
      freq_in      = freq_ff;
      fctx_in      = fctx_ff;
      fcode_in     = fcode_ff;
      q_we         = 1'b0;
      ent_we       = 1'b0;
      vec_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = STATUS_OK;
               rid_in       = id_ff;
               freq_in      = '0;
               fctx_in      = '0;
               fcode_in     = '0;
               unique case (act_ff)
                  ACTION_RESERVE: begin
                     if (used_ff == CNT_W'(NUM_IDS)) begin
                        status_in = STATUS_NO_FREE;
                        rid_in    = '0;
                     end else begin
                        rid_in           = got_id;
                        ent_we           = 1'b1;
                        busy_in[got_idx] = 1'b1;
                        head_in = (head_ff == IDX_W'(NUM_IDS - 1)) ? '0 : head_ff + 1'b1;
                        used_in = used_ff + 1'b1;
                     end
                  end
                  ACTION_RELEASE: begin
                     if (!busy_hit) begin
                        status_in = STATUS_REL_FREE;
                     end else begin
                        busy_in[id_idx] = 1'b0;
                        q_we            = 1'b1;
                        tail_in = (tail_ff == IDX_W'(NUM_IDS - 1)) ? '0 : tail_ff + 1'b1;
                        if (fill_ff != CNT_W'(NUM_IDS)) begin
                           fill_in = fill_ff + 1'b1;
                        end
                        used_in = used_ff - 1'b1;
                     end
                  end
                  ACTION_UPDATE: begin
                     if (!id_ok) begin
                        status_in = STATUS_MISS;
                     end else begin
                        vec_we = 1'b1;
                     end
                  end
                  ACTION_FIND: begin
                     if (!busy_hit || (chk_ff && (vec_rdata != {vhi_ff, vlo_ff}))) begin
                        status_in = STATUS_MISS;
                     end else begin
                        freq_in  = 32'(ent_rdata.request_tag);
                        fctx_in  = 32'(ent_rdata.context_tag);
                        fcode_in = ent_rdata.packet_code;
                     end
                  end
                  default: begin
                     status_in = STATUS_MISS;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         used_ff      <= '0;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         used_ff      <= used_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff     <= req_ch.action;
         id_ff      <= req_ch.id;
         req_tag_ff <= req_ch.request_tag;
         ctx_tag_ff <= req_ch.context_tag;
         code_ff    <= req_ch.packet_code;
         vhi_ff     <= req_ch.vector_high;
         vlo_ff     <= req_ch.vector_low;
         chk_ff     <= req_ch.check_vector;
      end
      status_ff <= status_in;
      rid_ff    <= rid_in;
      freq_ff   <= freq_in;
      fctx_ff   <= fctx_in;
      fcode_ff  <= fcode_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = status_ff;
   assign rsp_ch.result_id     = rid_ff;
   assign rsp_ch.found_request = freq_ff;
   assign rsp_ch.found_context = fctx_ff;
   assign rsp_ch.found_code    = fcode_ff;
   assign rsp_ch.in_use_count  = 9'(used_ff);

   `PIT_ASSERT_SAME(a_count_matches_flags, clock, reset, 1'b1,
                    used_ff == CNT_W'($countones(busy_ff)))
   `PIT_ASSERT_SAME(a_count_in_range, clock, reset, 1'b1, used_ff <= CNT_W'(NUM_IDS))
   `PIT_ASSERT_NEXT(a_accept_to_exec, clock, reset, req_fire, state_ff == ST_EXEC)
   `PIT_ASSERT_NEXT(a_exec_loads_rsp, clock, reset, exec_go,
                    rsp_valid_ff && (state_ff == ST_IDLE))

endmodule
